// ===== hw/rtl/ipa_pkg.sv =====
package ipa_pkg;

    // link store covers every id that a release can name
    localparam int unsigned RID_W      = 10;
    localparam int unsigned LINK_AW    = RID_W;
    localparam int unsigned LINK_DEPTH = 1024;
    localparam int unsigned ID_W       = 16;
    localparam int unsigned LINK_W     = ID_W;

    localparam logic [ID_W-1:0] NONE_ID = 16'hFFFF;

    typedef enum logic
    {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_BAD_RELEASE = 2'd2
    } rsp_status_t;

    typedef struct packed
    {
        op_t              op;
        logic [RID_W-1:0] release_id;
    } req_word_t;

    typedef struct packed
    {
        logic [ID_W-1:0] granted_id;
        rsp_status_t     status;
    } rsp_word_t;

    // one port of the link memory: read or write at one address per cycle
    typedef struct packed
    {
        logic               we;
        logic               re;
        logic [LINK_AW-1:0] addr;
        logic [LINK_W-1:0]  wdata;
    } link_req_t;

endpackage

// ===== hw/rtl/ipa_link_ram.sv =====
module ipa_link_ram
    import ipa_pkg::*;
(
    input  logic              clk,
    input  link_req_t         port,
    output logic [LINK_W-1:0] rdata
);

    logic [LINK_W-1:0] mem [LINK_DEPTH];
    logic [LINK_W-1:0] rdata_reg;

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (port.we)
        begin
            mem[port.addr] <= port.wdata;
        end
        if (port.re)
        begin
            rdata_reg <= mem[port.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/id_pool_allocator.sv =====
// id pool allocator: hands out and takes back numeric slot ids
//
// req channel (req_valid / req_stall / req): one word per operation, either an
// allocate or a release of req.release_id. rsp channel (rsp_valid / rsp_stall /
// rsp): exactly one word per request, carrying granted_id and status.
//
// each request passes through an accept cycle and the S_EXEC state: the accept
// cycle reads (allocate from the free list) or writes (release, tail link) the
// single-port link memory, and S_EXEC uses the registered read data, writes the
// granted or released id's link, updates the counters and loads the response
// register. the one memory port and its registered read data set this, so a new
// request is taken only once the last one has left S_EXEC; the response word is
// registered and becomes valid once the request commits in S_EXEC.
//
// the response register decouples the sides: a new request is taken while a
// finished response still waits. if rsp_stall holds, the next request stays in
// S_EXEC until the response register frees up.
//
// reset clears the counters and empties the free list. the link memory has no
// reset; only links of released ids are ever followed.
module id_pool_allocator
    import ipa_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES  = 1024,
    parameter int unsigned PAGE_ENTRIES = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

    // what the accept cycle decided for S_EXEC
    typedef enum logic [2:0]
    {
        K_ALLOC_HW,
        K_ALLOC_LIST,
        K_FULL,
        K_REL_OK,
        K_REL_BAD
    } kind_t;

    typedef enum logic
    {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t           state_reg, state_next;
    kind_t            kind_reg, kind_next;
    logic [RID_W-1:0] rid_reg, rid_next;
    logic [CNT_W-1:0] hw_reg, hw_next;        // next never-used id
    logic [CNT_W-1:0] cap_reg, cap_next;      // ids backed by pages
    logic [CNT_W-1:0] cnt_reg, cnt_next;      // free list length
    logic [ID_W-1:0]  head_reg, head_next;    // oldest free id, can be none
    logic [RID_W-1:0] tail_reg, tail_next;    // newest free id, valid when cnt > 0
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_word_t        rsp_reg, rsp_next;

    link_req_t         link_port;
    logic [LINK_W-1:0] link_rdata;

    logic              accept;
    logic              commit;
    logic              list_empty;
    logic              need_grow;
    logic              at_max;
    logic [31:0]       grown_sum;
    logic [CNT_W-1:0]  grown_cap;
    logic              rel_bad;
    logic              head_in_link;
    logic              hw_in_link;
    logic [ID_W-1:0]   head_succ;

    ipa_link_ram u_link_ram
    (
        .clk   (clk),
        .port  (link_port),
        .rdata (link_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign commit    = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);

    assign list_empty   = (cnt_reg == '0);
    assign need_grow    = list_empty && (hw_reg >= cap_reg);
    assign at_max       = (32'(cap_reg) >= MAX_ENTRIES);
    assign grown_sum    = 32'(cap_reg) + PAGE_ENTRIES;
    assign grown_cap    = (grown_sum > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : CNT_W'(grown_sum);
    assign rel_bad      = (32'(req.release_id) >= 32'(hw_reg)) || (cnt_reg >= hw_reg);
    assign head_in_link = (32'(head_reg) < LINK_DEPTH);
    assign hw_in_link   = (32'(hw_reg) < LINK_DEPTH);
    // ids past the link store read back as zero
    assign head_succ    = head_in_link ? link_rdata : '0;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        rid_next       = rid_reg;
        hw_next        = hw_reg;
        cap_next       = cap_reg;
        cnt_next       = cnt_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        link_port      = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (accept)
        begin
            state_next = S_EXEC;
            rid_next   = req.release_id;
            if (req.op == OP_ALLOC)
            begin
                if (need_grow && at_max)
                begin
                    kind_next = K_FULL;
                end
                else
                begin
                    if (need_grow)
                    begin
                        cap_next = grown_cap;
                    end
                    if (list_empty)
                    begin
                        kind_next = K_ALLOC_HW;
                    end
                    else
                    begin
                        // fetch the head's successor for S_EXEC
                        kind_next      = K_ALLOC_LIST;
                        link_port.re   = 1'b1;
                        link_port.addr = head_reg[LINK_AW-1:0];
                    end
                end
            end
            else if (rel_bad)
            begin
                kind_next = K_REL_BAD;
            end
            else
            begin
                kind_next = K_REL_OK;
                if (!list_empty)
                begin
                    // chain the released id behind the current tail
                    link_port.we    = 1'b1;
                    link_port.addr  = tail_reg;
                    link_port.wdata = LINK_W'(req.release_id);
                end
            end
        end

        if (commit)
        begin
            state_next     = S_IDLE;
            rsp_valid_next = 1'b1;
            unique case (kind_reg)
                K_ALLOC_HW:
                begin
                    rsp_next = '{granted_id: ID_W'(hw_reg), status: ST_OK};
                    hw_next  = CNT_W'(32'(hw_reg) + 32'd1);
                    if (hw_in_link)
                    begin
                        link_port.we    = 1'b1;
                        link_port.addr  = LINK_AW'(hw_reg);
                        link_port.wdata = NONE_ID;
                    end
                end
                K_ALLOC_LIST:
                begin
                    rsp_next = '{granted_id: head_reg, status: ST_OK};
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        head_next = NONE_ID;
                    end
                    else
                    begin
                        head_next = head_succ;
                    end
                    if (head_in_link)
                    begin
                        link_port.we    = 1'b1;
                        link_port.addr  = head_reg[LINK_AW-1:0];
                        link_port.wdata = NONE_ID;
                    end
                end
                K_FULL:
                begin
                    rsp_next = '{granted_id: NONE_ID, status: ST_FULL};
                end
                K_REL_OK:
                begin
                    rsp_next = '{granted_id: NONE_ID, status: ST_OK};
                    if (list_empty)
                    begin
                        head_next = ID_W'(rid_reg);
                    end
                    tail_next       = rid_reg;
                    cnt_next        = cnt_reg + CNT_W'(1);
                    link_port.we    = 1'b1;
                    link_port.addr  = rid_reg;
                    link_port.wdata = NONE_ID;
                end
                K_REL_BAD:
                begin
                    rsp_next = '{granted_id: NONE_ID, status: ST_BAD_RELEASE};
                end
                default:
                begin
                    rsp_next = '{granted_id: NONE_ID, status: ST_BAD_RELEASE};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= K_FULL;
            rid_reg       <= '0;
            hw_reg        <= '0;
            cap_reg       <= '0;
            cnt_reg       <= '0;
            head_reg      <= NONE_ID;
            tail_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '{granted_id: NONE_ID, status: ST_OK};
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            rid_reg       <= rid_next;
            hw_reg        <= hw_next;
            cap_reg       <= cap_next;
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // never more free ids than were ever handed out
    a_cnt_le_hw: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= hw_reg)
        else $error("free list longer than high-water mark");

    // ids are only granted from backed pages, and pages stop at the maximum
    a_hw_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (hw_reg <= cap_reg) && (32'(cap_reg) <= MAX_ENTRIES))
        else $error("high-water mark or capacity out of range");

    // an accepted request always moves on to S_EXEC
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted request not executed");

    // a new response only appears after an S_EXEC cycle
    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("response without execution");

endmodule
